FILE: rtl/sha256bs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256bs_pkg: shared types and constants for the SHA-256 byte hasher
// Word types for both channels, core control bundle, round constants and IV.
// ----------------------------------------------------------------------------
package sha256bs_pkg;

  // action codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // sequencer -> compression core
  typedef struct packed {
    logic       shift;    // shift byte_in into the message window
    logic [7:0] byte_in;
    logic       start;    // begin compressing the window
    logic       init;     // reload hash state with the IV
  } core_ctl_t;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: rtl/sha256bs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256bs_core: SHA-256 message window and iterative round engine
// Holds the 512-bit window, working variables and hash state; one round/cycle.
// ----------------------------------------------------------------------------
module sha256bs_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256bs_pkg::core_ctl_t ctl_i,
  output logic                   busy_o,
  output logic [7:0][31:0]       hash_o
);

  logic [511:0]      msg_r, msg_nxt;   // w[0] in the top word
  logic [7:0][31:0]  v_r, v_nxt;       // v[0] = a ... v[7] = h
  logic [7:0][31:0]  hash_r;
  logic [5:0]        rnd_r;
  logic              busy_r;
  logic              add_r;
  logic              round_en;

  logic [31:0] w0, w1, w9, w14, sig0, sig1, w_new;
  logic [31:0] a, e, big0, big1, ch, maj, t1, t2;

  assign round_en = busy_r && !add_r;

  // schedule
  always_comb begin
    w0    = msg_r[511:480];
    w1    = msg_r[479:448];
    w9    = msg_r[223:192];
    w14   = msg_r[63:32];
    sig0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    sig1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    w_new = w0 + sig0 + w9 + sig1;
  end

  // one compression round
  always_comb begin
    a    = v_r[0];
    e    = v_r[4];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch   = (e & v_r[5]) ^ (~e & v_r[6]);
    t1   = v_r[7] + big1 + ch + sha256bs_pkg::ROUND_K[rnd_r] + w0;
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    maj  = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
    v_nxt    = v_r;
    msg_nxt  = msg_r;
    if (ctl_i.start) begin
      v_nxt = hash_r;
    end else if (round_en) begin
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
    end
    if (ctl_i.shift) begin
      msg_nxt = {msg_r[503:0], ctl_i.byte_in};
    end else if (round_en) begin
      msg_nxt = {msg_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
    v_r   <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      rnd_r  <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256bs_pkg::HASH_IV[i];
    end else begin
      if (ctl_i.init) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= sha256bs_pkg::HASH_IV[i];
      end
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (round_en) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) add_r <= 1'b1;
      end else if (add_r) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
        add_r  <= 1'b0;
        busy_r <= 1'b0;
      end
    end
  end

  assign busy_o = busy_r;
  assign hash_o = hash_r;

`ifndef SYNTHESIS
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(ctl_i.start))
    else $error("core went busy without start");
  a_rounds_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (round_en && !ctl_i.start) |=> busy_r)
    else $error("core dropped busy during rounds");
  a_add_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (add_r && !ctl_i.start) |=> (!busy_r && !add_r))
    else $error("final add did not end compression");
`endif

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 over a byte stream
// Absorbs one byte per word, pads on finish and returns the 8 digest words.
// ----------------------------------------------------------------------------
// Flow for users: an absorb word shifts its byte into the message window; the
// 64th byte of a block also kicks off compression, which keeps in_stall high
// through the 64 rounds of the single round engine, one add into the hash
// state and one handoff. A finish word is followed by the padding, shifted
// into the message window one byte per cycle except while a spill block is
// compressed, and by one or two compressions: one with up to 55 bytes
// pending, two with more. The eight digest words then leave at one per cycle
// when the receiver does not stall; in_stall stays high until the last one is
// taken, after which the hasher is back at the initial hash value. The bit
// length wraps modulo 2^64.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha256bs_pkg::in_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sha256bs_pkg::out_t  out_word
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take words
  localparam logic [2:0] S_PAD  = 3'd1;  // shift zero bytes up to the length slot
  localparam logic [2:0] S_LEN  = 3'd2;  // shift the 8 length bytes
  localparam logic [2:0] S_COMP = 3'd3;  // wait on the round engine
  localparam logic [2:0] S_OUT  = 3'd4;  // hand out digest words

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;       // state to resume after compression
  logic [2:0]  ret_sel;
  logic [5:0]  fill_r, fill_nxt;     // bytes pending in the window
  logic [60:0] total_r, total_nxt;   // message length in bytes
  logic [63:0] len_r, len_nxt;       // bit length, shifted out MSB first
  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  sha256bs_pkg::out_t out_word_r, out_word_nxt;

  logic        do_shift;
  logic [7:0]  shift_byte;
  logic        out_take;

  sha256bs_pkg::core_ctl_t core_ctl;
  logic                    core_busy;
  logic [7:0][31:0]        core_hash;

  sha256bs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (core_ctl),
    .busy_o (core_busy),
    .hash_o (core_hash)
  );

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    ret_sel       = S_IDLE;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    do_shift      = 1'b0;
    shift_byte    = 8'h00;
    core_ctl      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          do_shift = 1'b1;
          if (in_word.action == sha256bs_pkg::ACT_ABSORB) begin
            shift_byte = in_word.data_byte;
            total_nxt  = total_r + 61'd1;
            ret_sel    = S_IDLE;
          end else begin
            shift_byte = sha256bs_pkg::PAD_BYTE;
            len_nxt    = {total_r, 3'b000};
            ret_sel    = S_PAD;
            state_nxt  = S_PAD;
          end
        end
      end
      S_PAD: begin
        // after a spill block this runs from zero up to the length slot
        if (fill_r == sha256bs_pkg::LEN_POS) begin
          state_nxt = S_LEN;
        end else begin
          do_shift = 1'b1;
          ret_sel  = S_PAD;
        end
      end
      S_LEN: begin
        do_shift   = 1'b1;
        shift_byte = len_r[63:56];
        len_nxt    = {len_r[55:0], 8'h00};
        ret_sel    = S_OUT;
      end
      S_COMP: begin
        if (!core_busy) begin
          state_nxt = ret_r;
          if (ret_r == S_OUT) begin
            out_valid_nxt            = 1'b1;
            idx_nxt                  = 3'd0;
            out_word_nxt.digest_word = core_hash[0];
            out_word_nxt.word_index  = 3'd0;
            out_word_nxt.last_word   = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (out_take) begin
          if (idx_r == sha256bs_pkg::LAST_IDX) begin
            out_valid_nxt = 1'b0;
            core_ctl.init = 1'b1;
            total_nxt     = '0;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt                  = idx_r + 3'd1;
            out_word_nxt.digest_word = core_hash[idx_nxt];
            out_word_nxt.word_index  = idx_nxt;
            out_word_nxt.last_word   = (idx_nxt == sha256bs_pkg::LAST_IDX);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // common byte path: a full window starts compression
    if (do_shift) begin
      core_ctl.shift   = 1'b1;
      core_ctl.byte_in = shift_byte;
      fill_nxt         = fill_r + 6'd1;
      if (fill_r == sha256bs_pkg::FILL_LAST) begin
        core_ctl.start = 1'b1;
        ret_nxt        = ret_sel;
        state_nxt      = S_COMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_out_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!core_busy && fill_r == 6'd0))
    else $error("digest word shown while hashing");
  a_no_shift_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_ctl.shift |-> !core_busy)
    else $error("byte shifted into window during compression");
  a_last_word_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_word_r.last_word) |=> (!out_valid_r && state_r == S_IDLE))
    else $error("hasher did not return to idle after last digest word");
`endif

endmodule

FILE: tb/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb: self-checking bench for the SHA-256 hasher
// Streams messages one byte per word into the hasher and checks each digest
// word against an in-bench SHA-256 model, with random idling on both sides.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;

  localparam int RANDOM_ITEMS = 330;  // stop adding random messages past this
  localparam int TAIL_ITEMS   = 40;   // last stretch runs with no idling
  localparam int SETTLE_CYC   = 300;  // covers a two-block finish
  localparam int MAX_PRINTS   = 40;

  // one queued stimulus word; drain_first holds it back until all digest
  // words predicted so far have come out
  typedef struct {
    sha256bs_pkg::in_t word;
    bit                drain_first;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha256bs_pkg::in_t  in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha256bs_pkg::out_t out_word;

  stim_t              pending_q[$];
  sha256bs_pkg::out_t digest_q[$];

  // in-bench hash state
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  int          fill_cnt;
  logic [60:0] msg_bytes;

  int  err_count = 0;
  int  words_due = 0;     // digest words predicted (driver side, blocking)
  int  words_seen = 0;    // digest words taken (monitor side, registered)
  int  msgs_done = 0;
  int  bytes_in = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  stim_total = 0;
  logic tail_phase = 1'b0;
  logic in_take;
  sha256bs_pkg::out_t due_word;

  sha256_byte_stream_hasher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // SHA-256 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hasher_reset();
    chain_h   = sha256bs_pkg::HASH_IV;
    fill_cnt  = 0;
    msg_bytes = '0;
  endfunction

  // one 64-round compression of blk_bytes into chain_h
  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain_h;
    for (int i = 0; i < 64; i++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha256bs_pkg::ROUND_K[i] + w[i];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_h[i] = chain_h[i] + v[i];
  endfunction

  // advance the model by one accepted word; a finish queues 8 digest words
  function automatic void predict_word(sha256bs_pkg::in_t w);
    logic [63:0]        bit_len;
    sha256bs_pkg::out_t dw;
    if (w.action == sha256bs_pkg::ACT_ABSORB) begin
      blk_bytes[fill_cnt] = w.data_byte;
      fill_cnt++;
      msg_bytes = msg_bytes + 61'd1;   // wraps mod 2^61
      bytes_in++;
      if (fill_cnt == 64) begin
        sha_compress();
        fill_cnt = 0;
      end
    end else begin
      bit_len = {msg_bytes, 3'b000};
      blk_bytes[fill_cnt] = sha256bs_pkg::PAD_BYTE;
      fill_cnt++;
      // no room for the length: pad out and spill into one more block
      if (fill_cnt > int'(sha256bs_pkg::LEN_POS)) begin
        for (int i = fill_cnt; i < 64; i++) blk_bytes[i] = 8'h00;
        sha_compress();
        fill_cnt = 0;
      end
      for (int i = fill_cnt; i < int'(sha256bs_pkg::LEN_POS); i++) blk_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++)
        blk_bytes[int'(sha256bs_pkg::LEN_POS) + i] = bit_len[63 - 8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = chain_h[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (3'(i) == sha256bs_pkg::LAST_IDX);
        digest_q = {digest_q, dw};
      end
      words_due += 8;
      msgs_done++;
      hasher_reset();
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b, bit drain);
    stim_t s;
    s.word.action    = sha256bs_pkg::ACT_ABSORB;
    s.word.data_byte = b;
    s.drain_first    = drain;
    pending_q = {pending_q, s};
    stim_total++;
  endtask

  // data_byte on a finish is don't-care; keep it random so all bits toggle
  task automatic queue_finish(bit drain);
    stim_t s;
    s.word.action    = sha256bs_pkg::ACT_FINISH;
    s.word.data_byte = 8'($urandom_range(0, 255));
    s.drain_first    = drain;
    pending_q = {pending_q, s};
    stim_total++;
  endtask

  task automatic queue_message(int len, bit drain);
    for (int i = 0; i < len; i++)
      queue_byte(8'($urandom_range(0, 255)), drain && i == 0);
    queue_finish(drain && len == 0);
  endtask

  task automatic report_mismatch(string what);
    if (err_count < MAX_PRINTS)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // driver: presents queued words, holds them while stalled, and idles in
  // random bursts after some accepted words (never in the tail)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      tail_phase <= 1'b0;
      gap_left   = 0;
      hasher_reset();
    end else begin
      in_take = in_valid && !in_stall;
      if (in_take)
        predict_word(in_word);
      tail_phase <= (pending_q.size() < TAIL_ITEMS);
      if (!in_valid || in_take) begin
        if (in_take && !tail_phase && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 6);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && words_seen != words_due)) begin
          in_word  <= pending_q[0].word;
          in_valid <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each taken digest word against the oldest prediction and
  // stalls the result side in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      words_seen <= 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    out_word.digest_word, out_word.word_index));
        end else begin
          due_word = digest_q.pop_front();
          if (out_word.digest_word !== due_word.digest_word)
            report_mismatch($sformatf("digest_word got %h want %h (index %0d)",
                                      out_word.digest_word, due_word.digest_word,
                                      due_word.word_index));
          if (out_word.word_index !== due_word.word_index)
            report_mismatch($sformatf("word_index got %0d want %0d",
                                      out_word.word_index, due_word.word_index));
          if (out_word.last_word !== due_word.last_word)
            report_mismatch($sformatf("last_word got %b want %b (index %0d)",
                                      out_word.last_word, due_word.last_word,
                                      due_word.word_index));
        end
        words_seen <= words_seen + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: directed messages, then random ones, reset, drain and verdict
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int len;
    int pick;
    // directed: empty message, single-byte extremes, then "abc"
    queue_finish(1'b0);
    queue_byte(8'h00, 1'b0);
    queue_finish(1'b0);
    queue_byte(8'hff, 1'b0);
    queue_finish(1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_finish(1'b0);

    // fill right up to the length field, one past it (long tail), and an
    // exact block; the long-tail one waits for the pipe to empty first
    queue_message(55, 1'b0);
    queue_message(56, 1'b1);
    queue_message(64, 1'b0);
    while (stim_total < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        case ($urandom_range(0, 5))
          0: len = 57;
          1: len = 63;
          2: len = 65;
          3: len = 119;
          4: len = 120;
          default: len = 56;
        endcase
      end else begin
        len = $urandom_range(0, 20);
      end
      // keep the word count near the target
      if (len > RANDOM_ITEMS - stim_total - 1)
        len = RANDOM_ITEMS - stim_total - 1;
      queue_message(len, 1'b0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || digest_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("Hashed %0d messages (%0d bytes) incl. empty, boundary and two-block tails;",
             msgs_done, bytes_in);
    $display("checked %0d digest words, %0d mismatches.", words_seen, err_count);
    if (err_count == 0) begin
      $display("sha256_byte_stream_hasher_tb passed");
    end else begin
      $display("sha256_byte_stream_hasher_tb failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20000000;
    $display("Timeout: %0d words still queued, %0d digest words outstanding",
             pending_q.size(), digest_q.size());
    $display("sha256_byte_stream_hasher_tb failed");
    $finish;
  end

endmodule
